// File: hdl/mlbt_pkg.sv
// Shared constants, default parameters and controller/datapath link types for the lane transposer.
package mlbt_pkg;

  // Port widths of the beat fields.
  localparam int unsigned LANE_W = 32;
  localparam int unsigned CHIP_W = 5;
  localparam int unsigned WORD_W = 11;
  localparam int unsigned DATA_W = 16;

  // Default configuration of the transposer.
  localparam int unsigned DEF_WORDS_PER_CHIP = 1924;
  localparam int unsigned DEF_LANES          = 32;
  localparam int unsigned DEF_BITS_PER_WORD  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // an input beat is accepted this cycle
    logic emit;  // load the next enabled lane into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic grp_emit;   // the offered beat completes a group with enabled lanes
    logic pend_any;   // lanes of the finished group still wait to be sent
    logic pend_last;  // the lane selected now is the last one of the group
    logic slot_free;  // the output register can take a new result
  } sts_t;

endpackage

// File: hdl/mlbt_ctrl.sv
// Controller: alternates between taking input beats and draining a finished group.
module mlbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mlbt_pkg::sts_t sts,
  output mlbt_pkg::cmd_t cmd
);
  import mlbt_pkg::*;

  typedef enum logic {
    ST_TAKE,
    ST_EMIT
  } state_t;

  state_t state_r;

  // Input is only taken while no group is being drained.
  assign in_ready = (state_r == ST_TAKE);
  assign cmd.take = in_valid && in_ready;
  assign cmd.emit = (state_r == ST_EMIT) && sts.slot_free;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAKE;
    end else begin
      unique case (state_r)
        ST_TAKE: begin
          if (cmd.take && sts.grp_emit) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.emit && sts.pend_last) begin
            state_r <= ST_TAKE;
          end
        end
        default: state_r <= ST_TAKE;
      endcase
    end
  end

  // While draining, the datapath must still hold lanes to send.
  a_emit_has_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> sts.pend_any)
    else $error("controller drains a group with no pending lanes");

  // A group with enabled lanes always moves the controller into draining.
  a_grp_enters_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && sts.grp_emit |=> state_r == ST_EMIT)
    else $error("completed group did not start draining");

endmodule

// File: hdl/mlbt_dpath.sv
// Datapath: lane shift registers, frame counters, lane selection and output register.
module mlbt_dpath #(
  parameter int unsigned WORDS_PER_CHIP = mlbt_pkg::DEF_WORDS_PER_CHIP,
  parameter int unsigned LANES          = mlbt_pkg::DEF_LANES,
  parameter int unsigned BITS_PER_WORD  = mlbt_pkg::DEF_BITS_PER_WORD
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlbt_pkg::cmd_t               cmd,
  output mlbt_pkg::sts_t               sts,
  input  logic                         cfg_wr_en,
  input  logic [mlbt_pkg::LANE_W-1:0]  cfg_wr_data,
  input  logic                         in_frame_start,
  input  logic [mlbt_pkg::LANE_W-1:0]  in_lane_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mlbt_pkg::CHIP_W-1:0]  out_chip_index,
  output logic [mlbt_pkg::WORD_W-1:0]  out_word_index,
  output logic [mlbt_pkg::DATA_W-1:0]  out_decoded_word,
  output logic                         out_run_last,
  output logic                         out_frame_done
);
  import mlbt_pkg::*;

  localparam int unsigned BCW = (BITS_PER_WORD > 2) ? $clog2(BITS_PER_WORD) : 1;

  // Configuration and frame state.
  logic [LANE_W-1:0]        lane_mask_r;
  logic [BITS_PER_WORD-1:0] lane_sh_r [LANES];
  logic [BCW-1:0]           bit_cnt_r, bit_cnt_nxt;
  logic [WORD_W-1:0]        word_cnt_r, word_cnt_nxt;
  logic                     frm_closed_r, frm_closed_nxt;

  // Group drain state.
  logic [LANES-1:0]         pend_r, pend_nxt;
  logic [WORD_W-1:0]        grp_word_r;
  logic                     grp_fdone_r;
  logic [CHIP_W-1:0]        chip_cnt_r, chip_cnt_nxt;

  // Output register.
  logic                     out_valid_r;
  logic [CHIP_W-1:0]        out_chip_r;
  logic [WORD_W-1:0]        out_word_r;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_last_r;
  logic                     out_fdone_r;

  logic                     open_now;
  logic                     grp_done;
  logic                     grp_last_word;
  logic [LANES-1:0]         eff_mask;
  logic [LANES-1:0]         low_bit;
  logic [LANES-1:0]         pend_rest;
  logic [BITS_PER_WORD-1:0] sel_word;

  // Group completion for the beat currently offered.
  always_comb begin
    open_now      = in_frame_start || !frm_closed_r;
    grp_done      = open_now &&
                    ((in_frame_start ? '0 : bit_cnt_r) == BCW'(BITS_PER_WORD - 1));
    grp_last_word = (in_frame_start ? '0 : word_cnt_r) >= WORD_W'(WORDS_PER_CHIP - 1);
    eff_mask      = lane_mask_r[LANES-1:0];
  end

  // Counter and frame state updates on an accepted beat.
  always_comb begin
    bit_cnt_nxt    = bit_cnt_r;
    word_cnt_nxt   = word_cnt_r;
    frm_closed_nxt = frm_closed_r;
    if (cmd.take) begin
      if (in_frame_start) begin
        bit_cnt_nxt    = '0;
        word_cnt_nxt   = '0;
        frm_closed_nxt = 1'b0;
      end
      if (open_now) begin
        if (grp_done) begin
          bit_cnt_nxt = '0;
          if (grp_last_word) begin
            word_cnt_nxt   = '0;
            frm_closed_nxt = 1'b1;
          end else begin
            word_cnt_nxt = (in_frame_start ? '0 : word_cnt_r) + WORD_W'(1);
          end
        end else begin
          bit_cnt_nxt = (in_frame_start ? '0 : bit_cnt_r) + BCW'(1);
        end
      end
    end
  end

  // Lowest pending lane and its assembled word.
  always_comb begin
    low_bit   = pend_r & (~pend_r + LANES'(1));
    pend_rest = pend_r & ~low_bit;
    sel_word  = '0;
    for (int n = 0; n < LANES; n++) begin
      sel_word = sel_word | (low_bit[n] ? lane_sh_r[n] : '0);
    end
  end

  // Pending lanes and rank counter.
  always_comb begin
    pend_nxt     = pend_r;
    chip_cnt_nxt = chip_cnt_r;
    if (cmd.emit) begin
      pend_nxt     = pend_rest;
      chip_cnt_nxt = chip_cnt_r + CHIP_W'(1);
    end
    if (cmd.take && grp_done) begin
      pend_nxt     = eff_mask;
      chip_cnt_nxt = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_mask_r  <= '0;
      bit_cnt_r    <= '0;
      word_cnt_r   <= '0;
      frm_closed_r <= 1'b1;
      pend_r       <= '0;
      chip_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lane_mask_r <= cfg_wr_data;
      end
      bit_cnt_r    <= bit_cnt_nxt;
      word_cnt_r   <= word_cnt_nxt;
      frm_closed_r <= frm_closed_nxt;
      pend_r       <= pend_nxt;
      chip_cnt_r   <= chip_cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Lane shift registers: every lane shifts on each beat of an open frame.
  always_ff @(posedge clk) begin
    if (cmd.take && open_now) begin
      for (int n = 0; n < LANES; n++) begin
        lane_sh_r[n] <= {lane_sh_r[n][BITS_PER_WORD-2:0], in_lane_bits[n]};
      end
    end
  end

  // Group snapshot and output payload.
  always_ff @(posedge clk) begin
    if (cmd.take && grp_done) begin
      grp_word_r  <= in_frame_start ? '0 : word_cnt_r;
      grp_fdone_r <= grp_last_word;
    end
    if (cmd.emit) begin
      out_chip_r  <= chip_cnt_r;
      out_word_r  <= grp_word_r;
      out_data_r  <= DATA_W'(sel_word);
      out_last_r  <= (pend_rest == '0);
      out_fdone_r <= (pend_rest == '0) && grp_fdone_r;
    end
  end

  assign sts.grp_emit  = grp_done && (eff_mask != '0);
  assign sts.pend_any  = (pend_r != '0);
  assign sts.pend_last = (pend_rest == '0);
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_chip_index   = out_chip_r;
  assign out_word_index   = out_word_r;
  assign out_decoded_word = out_data_r;
  assign out_run_last     = out_last_r;
  assign out_frame_done   = out_fdone_r;

  // A closed frame always has its counters cleared.
  a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frm_closed_r |-> (bit_cnt_r == '0 && word_cnt_r == '0))
    else $error("counters not cleared while no frame is open");

  // The frame end flag only ever rides on the last lane of a group.
  a_fdone_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fdone_r |-> out_last_r)
    else $error("frame end flagged on a lane that is not the last");

  // A result is loaded only when a lane is pending.
  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> pend_r != '0)
    else $error("result loaded with no pending lane");

endmodule

// File: hdl/masked_lane_bit_transpose.sv
// Top level of the masked lane bit transposer: controller plus datapath.
//
// Usage: each input beat carries one bit from each serial lane (bit n is
// lane n) and a frame start flag. Every BITS_PER_WORD beats of an open frame
// form one word group; for each lane enabled in the lane mask the block then
// sends one result with the lane's rank, the group number and the assembled
// word, first received bit in the MSB, in ascending lane order.
// The user must write the lane mask through cfg_wr_en/cfg_wr_data only while
// the block idles; the block itself does not enforce this. The first result
// of a group is loaded once the controller has entered its drain state and the
// output register is free; results then follow at one per cycle while the
// receiver takes them. in_ready is low while a group's results are loaded
// into the single output register.
// Reset clears the lane mask and counters; no frame is open until a beat with
// in_frame_start arrives, and beats outside a frame are taken and dropped.
// When the receiver stalls, the output register holds its result and the
// lane drain pauses; input is accepted again once the last result is loaded.
module masked_lane_bit_transpose #(
  parameter int unsigned WORDS_PER_CHIP = mlbt_pkg::DEF_WORDS_PER_CHIP,
  parameter int unsigned LANES          = mlbt_pkg::DEF_LANES,
  parameter int unsigned BITS_PER_WORD  = mlbt_pkg::DEF_BITS_PER_WORD
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mlbt_pkg::LANE_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_frame_start,
  input  logic [mlbt_pkg::LANE_W-1:0]  in_lane_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mlbt_pkg::CHIP_W-1:0]  out_chip_index,
  output logic [mlbt_pkg::WORD_W-1:0]  out_word_index,
  output logic [mlbt_pkg::DATA_W-1:0]  out_decoded_word,
  output logic                         out_run_last,
  output logic                         out_frame_done
);
  import mlbt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of beats and group drains.
  mlbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Shift registers, counters and output register.
  mlbt_dpath #(
    .WORDS_PER_CHIP (WORDS_PER_CHIP),
    .LANES          (LANES),
    .BITS_PER_WORD  (BITS_PER_WORD)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_frame_start   (in_frame_start),
    .in_lane_bits     (in_lane_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chip_index   (out_chip_index),
    .out_word_index   (out_word_index),
    .out_decoded_word (out_decoded_word),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done)
  );

endmodule
